### design/nqss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqss_pkg: shared types and constants of the N-queens search unit
// Field widths, limits and the control word handed from the sequencer to
// each cell of the placement chain.
// ----------------------------------------------------------------------------
package nqss_pkg;

	localparam int ROW_W         = 4;
	localparam int SIZE_W        = 5;
	localparam int CNT_W         = 2;
	localparam int MAX_N_DEFAULT = 16;
	localparam int LIMIT_RESET   = 3;
	localparam int MAX_SOLUTIONS = 3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_FINAL
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [SIZE_W-1:0]   cand;
		logic [SIZE_W-1:0]   depth;
	} cell_ctrl_t;

endpackage

### design/n_queens_solution_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_search_unit: backtracking N-queens solver
// Depth-first search over a chain of placement cells; solutions are streamed
// out one word per column.
// ----------------------------------------------------------------------------
//
//  channel  | direction | words per request | handshake
//  ---------+-----------+-------------------+--------------------------
//  in       | input     | 1 (board_size)    | in_valid / in_ready
//  out      | output    | 1 to 3*MAX_N      | out_valid / out_ready
//  cfg      | input     | write only        | cfg_wr_en, no wait
//
// A search step is one node of the search tree: try, advance or backtrack.
// For each solution the emit state streams columns 0 to n-2 by rotations of
// the chain, then holds and parks column n-1 until the next step shows
// whether it is the last word. A parked word goes out first when the next
// solution is found, or as the final word.
// Reset clears the sequencer and the output valid flag; the cells need none.
// A stalled output holds only the emission: the search runs on while a word
// waits and stops at the next solution until the output register is free.
// A new request is taken only once the previous final word is loaded.
//
module n_queens_solution_search_unit import nqss_pkg::*; #(
	parameter int MAX_N = MAX_N_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SIZE_W-1:0] board_size,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              has_queen,
	output logic [CNT_W-1:0]  solution_index,
	output logic [ROW_W-1:0]  column_index,
	output logic [ROW_W-1:0]  row_value,
	output logic              end_of_solution,
	output logic              last
);

	localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  limit_reg_q;
	logic [CNT_W-1:0]  limit_q, limit_d;
	logic [SIZE_W-1:0] n_q, n_d;
	logic [SIZE_W-1:0] depth_q, depth_d;
	logic [SIZE_W-1:0] cand_q, cand_d;
	logic [SIZE_W-1:0] k_q, k_d;
	logic [CNT_W-1:0]  found_q, found_d;

	// The final column of the latest solution waits here, since only the
	// next step of the search tells whether it is the last word.
	logic              pend_valid_q, pend_valid_d;
	logic [CNT_W-1:0]  pend_sol_q, pend_sol_d;
	logic [ROW_W-1:0]  pend_col_q, pend_col_d;
	logic [ROW_W-1:0]  pend_row_q, pend_row_d;

	logic              out_load;
	logic              can_load;
	logic              o_has, o_eos, o_last;
	logic [CNT_W-1:0]  o_sol;
	logic [ROW_W-1:0]  o_col, o_row;

	cell_ctrl_t        ctrl;
	logic [ROW_W-1:0]  rows [MAX_N];
	logic [MAX_N-1:0]  conflicts;
	logic [IDX_W-1:0]  last_idx;
	logic [SIZE_W-1:0] n_in;

	assign can_load = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign last_idx = IDX_W'(n_q - SIZE_W'(1));
	assign n_in     = (board_size > SIZE_W'(MAX_N)) ? SIZE_W'(MAX_N) : board_size;

	// The chain: cell 0 is the top of the placement stack.
	for (genvar j = 0; j < MAX_N; j++) begin : g_cell
		logic [ROW_W-1:0] left_w, right_w;
		if (j == 0) begin : g_head
			assign left_w = (ctrl.op == CELL_PUSH) ? ctrl.cand[ROW_W-1:0] : rows[last_idx];
		end else begin : g_body
			assign left_w = rows[j-1];
		end
		if (j == MAX_N - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = rows[j+1];
		end
		nqss_cell #(.IDX(j)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.din_left  (left_w),
			.din_right (right_w),
			.row       (rows[j]),
			.conflict  (conflicts[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			limit_reg_q  <= CNT_W'(LIMIT_RESET);
			pend_valid_q <= 1'b0;
			out_valid    <= 1'b0;
			found_q      <= '0;
			depth_q      <= '0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= pend_valid_d;
			found_q      <= found_d;
			depth_q      <= depth_d;
			if (cfg_wr_en) begin
				limit_reg_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		limit_q    <= limit_d;
		n_q        <= n_d;
		cand_q     <= cand_d;
		k_q        <= k_d;
		pend_sol_q <= pend_sol_d;
		pend_col_q <= pend_col_d;
		pend_row_q <= pend_row_d;
		if (out_load) begin
			has_queen       <= o_has;
			solution_index  <= o_sol;
			column_index    <= o_col;
			row_value       <= o_row;
			end_of_solution <= o_eos;
			last            <= o_last;
		end
	end

	always_comb begin
		state_d      = state_q;
		limit_d      = limit_q;
		n_d          = n_q;
		depth_d      = depth_q;
		cand_d       = cand_q;
		k_d          = k_q;
		found_d      = found_q;
		pend_valid_d = pend_valid_q;
		pend_sol_d   = pend_sol_q;
		pend_col_d   = pend_col_q;
		pend_row_d   = pend_row_q;
		out_load     = 1'b0;
		o_has        = 1'b0;
		o_sol        = '0;
		o_col        = '0;
		o_row        = '0;
		o_eos        = 1'b0;
		o_last       = 1'b0;
		ctrl.op      = CELL_HOLD;
		ctrl.cand    = cand_q;
		ctrl.depth   = depth_q;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_d          = n_in;
					limit_d      = (limit_reg_q == '0) ? CNT_W'(1) : limit_reg_q;
					depth_d      = '0;
					cand_d       = '0;
					found_d      = '0;
					pend_valid_d = 1'b0;
					state_d      = (n_in == '0) ? ST_FINAL : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (cand_q >= n_q) begin
					if (depth_q == '0) begin
						state_d = ST_FINAL;
					end else begin
						ctrl.op = CELL_POP;
						cand_d  = {1'b0, rows[0]} + SIZE_W'(1);
						depth_d = depth_q - SIZE_W'(1);
					end
				end else if (conflicts == '0) begin
					ctrl.op = CELL_PUSH;
					depth_d = depth_q + SIZE_W'(1);
					cand_d  = '0;
					if (depth_q == n_q - SIZE_W'(1)) begin
						k_d     = '0;
						state_d = ST_EMIT;
					end
				end else begin
					cand_d = cand_q + SIZE_W'(1);
				end
			end
			ST_EMIT: begin
				if (pend_valid_q) begin
					// The previous solution's final column goes out first.
					if (can_load) begin
						out_load     = 1'b1;
						o_has        = 1'b1;
						o_sol        = pend_sol_q;
						o_col        = pend_col_q;
						o_row        = pend_row_q;
						o_eos        = 1'b1;
						pend_valid_d = 1'b0;
					end
				end else if (k_q == n_q - SIZE_W'(1)) begin
					// The chain holds here: it already stands in popped order.
					pend_valid_d = 1'b1;
					pend_sol_d   = found_q;
					pend_col_d   = k_q[ROW_W-1:0];
					pend_row_d   = rows[last_idx];
					found_d      = found_q + CNT_W'(1);
					if (found_q + CNT_W'(1) >= limit_q) begin
						state_d = ST_FINAL;
					end else begin
						state_d = ST_SEARCH;
					end
				end else if (can_load) begin
					ctrl.op  = CELL_ROT;
					out_load = 1'b1;
					o_has    = 1'b1;
					o_sol    = found_q;
					o_col    = k_q[ROW_W-1:0];
					o_row    = rows[last_idx];
					k_d      = k_q + SIZE_W'(1);
				end
				// Back to the search: the solution's last row is retried one up.
				if (state_d == ST_SEARCH) begin
					cand_d = cand_q;
				end
			end
			ST_FINAL: begin
				if (can_load) begin
					out_load     = 1'b1;
					o_has        = pend_valid_q;
					o_sol        = pend_valid_q ? pend_sol_q : '0;
					o_col        = pend_valid_q ? pend_col_q : '0;
					o_row        = pend_valid_q ? pend_row_q : '0;
					o_eos        = pend_valid_q;
					o_last       = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// After a solution that is not the last, the search resumes from a
		// popped state: depth n-1 with the final row advanced by one.
		if (state_q == ST_EMIT && state_d == ST_SEARCH) begin
			depth_d = depth_q - SIZE_W'(1);
			cand_d  = {1'b0, rows[last_idx]} + SIZE_W'(1);
		end
	end

	// Note on the resume path: after the n-1 rotations of the emit state,
	// cell j holds the queen of column n-2-j for every j below n-1, which is
	// the pushed order with the top removed. Holding the chain in the final
	// emit cycle therefore gives the pop for free, and depth n-1 masks the
	// stale cell n-1.

`ifndef SYNTH
	a_depth_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (depth_q < n_q))
		else $error("search depth reached board size");
	a_pend_matches_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (pend_valid_q == (found_q != '0)))
		else $error("held word disagrees with solution count");
	a_found_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (found_q <= limit_q))
		else $error("solution count passed the limit");
	a_last_ends_request: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && o_last) |=> (state_q == ST_IDLE))
		else $error("final word loaded while request still running");
`endif

endmodule

### design/nqss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqss_cell: one entry of the placement chain
// Holds the row of one placed queen, shifts with its neighbours and flags
// whether the candidate row is attacked by its queen.
// ----------------------------------------------------------------------------
module nqss_cell import nqss_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [ROW_W-1:0]  din_left,
	input  logic [ROW_W-1:0]  din_right,
	output logic [ROW_W-1:0]  row,
	output logic              conflict
);

	// Cell IDX holds the queen placed IDX+1 columns before the candidate.
	localparam logic [SIZE_W-1:0] DIST = SIZE_W'(IDX + 1);
	localparam logic [SIZE_W-1:0] POS  = SIZE_W'(IDX);

	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] row_ext;
	logic [SIZE_W-1:0] diff;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_PUSH, CELL_ROT: row_q <= din_left;
			CELL_POP:            row_q <= din_right;
			default:             row_q <= row_q;
		endcase
	end

	always_comb begin
		row_ext  = {1'b0, row_q};
		diff     = (row_ext > ctrl.cand) ? row_ext - ctrl.cand : ctrl.cand - row_ext;
		conflict = (POS < ctrl.depth) && ((row_ext == ctrl.cand) || (diff == DIST));
	end

	assign row = row_q;

endmodule

### tb/n_queens_solution_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_search_unit_tb: self-checking bench of the N-queens unit
// Board sizes are sent under several solution limits. A scoreboard runs its
// own backtracking search for each accepted size and checks every result
// word, field by field, against the placements it predicts.
// ----------------------------------------------------------------------------
module n_queens_solution_search_unit_tb;
	import nqss_pkg::*;

	typedef struct {
		logic             has_queen;
		logic [CNT_W-1:0] solution_index;
		logic [ROW_W-1:0] column_index;
		logic [ROW_W-1:0] row_value;
		logic             end_of_solution;
		logic             last;
	} placement_word_t;

	// The scoreboard keeps its own copy of the limit register and the queue
	// of words that the searches seen so far should produce.
	class queens_scoreboard;
		logic [CNT_W-1:0] limit_reg;
		placement_word_t  expected_words[$];
		int               errors;

		function new();
			limit_reg = CNT_W'(LIMIT_RESET);
			errors    = 0;
		endfunction

		function void note_size(logic [SIZE_W-1:0] size);
			int rows[17];
			int sols[MAX_SOLUTIONS][16];
			int n, lim, found, col, k, d, s, c;
			bit ok;
			placement_word_t w;
			n     = (size > 16) ? 16 : size;
			lim   = (limit_reg == 0) ? 1 : limit_reg;
			found = 0;
			col   = 0;
			if (n > 0) begin
				rows[0] = 0;
				while (col >= 0) begin
					if (rows[col] >= n) begin
						col--;
						if (col >= 0)
							rows[col]++;
					end else begin
						ok = 1;
						for (k = 0; k < col; k++) begin
							d = rows[k] - rows[col];
							if (d < 0)
								d = -d;
							if (d == 0 || d == col - k)
								ok = 0;
						end
						if (!ok) begin
							rows[col]++;
						end else if (col == n - 1) begin
							for (c = 0; c < n; c++)
								sols[found][c] = rows[c];
							found++;
							if (found >= lim)
								break;
							rows[col]++;
						end else begin
							col++;
							rows[col] = 0;
						end
					end
				end
			end
			if (found == 0) begin
				w = '{1'b0, '0, '0, '0, 1'b0, 1'b1};
				expected_words.push_back(w);
			end
			for (s = 0; s < found; s++)
				for (c = 0; c < n; c++) begin
					w.has_queen       = 1'b1;
					w.solution_index  = CNT_W'(s);
					w.column_index    = ROW_W'(c);
					w.row_value       = ROW_W'(sols[s][c]);
					w.end_of_solution = (c == n - 1);
					w.last            = (s == found - 1) && (c == n - 1);
					expected_words.push_back(w);
				end
		endfunction

		function void check_word(placement_word_t got);
			placement_word_t exp;
			if (expected_words.size() == 0) begin
				$error("unexpected result word");
				errors++;
				return;
			end
			exp = expected_words.pop_front();
			if (got.has_queen !== exp.has_queen) begin
				$error("has_queen: expected %0d, got %0d", exp.has_queen, got.has_queen);
				errors++;
			end
			if (got.solution_index !== exp.solution_index) begin
				$error("solution_index: expected %0d, got %0d",
					exp.solution_index, got.solution_index);
				errors++;
			end
			if (got.column_index !== exp.column_index) begin
				$error("column_index: expected %0d, got %0d",
					exp.column_index, got.column_index);
				errors++;
			end
			if (got.row_value !== exp.row_value) begin
				$error("row_value: expected %0d, got %0d", exp.row_value, got.row_value);
				errors++;
			end
			if (got.end_of_solution !== exp.end_of_solution) begin
				$error("end_of_solution: expected %0d, got %0d",
					exp.end_of_solution, got.end_of_solution);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0d, got %0d", exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CNT_W-1:0]  cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	logic [SIZE_W-1:0] board_size;
	logic              out_valid;
	logic              out_ready;
	logic              has_queen;
	logic [CNT_W-1:0]  solution_index;
	logic [ROW_W-1:0]  column_index;
	logic [ROW_W-1:0]  row_value;
	logic              end_of_solution;
	logic              last;

	queens_scoreboard sb;
	int               idle_cycles = 0;
	bit               sink_fast;	// when set the sink never stalls
	bit               source_fast;	// when set the source sends back to back

	n_queens_solution_search_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.board_size     (board_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.has_queen      (has_queen),
		.solution_index (solution_index),
		.column_index   (column_index),
		.row_value      (row_value),
		.end_of_solution(end_of_solution),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 3);
		return $urandom_range(15, 80);
	endfunction

	// The watchdog counts cycles in which neither channel moves a word. Its
	// limit must lie well above the longest stretch of a 16-queens search
	// with nothing moving.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result sink: ready is changed on the falling edge and the word is
	// taken on the rising edge, so each stall lands on a different phase of
	// the unit's emission.
	initial begin : sink
		int stall;
		placement_word_t got;
		out_ready = 1'b0;
		stall     = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				if (!sink_fast && $urandom_range(0, 3) == 0)
					stall = gap_length();
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.has_queen       = has_queen;
				got.solution_index  = solution_index;
				got.column_index    = column_index;
				got.row_value       = row_value;
				got.end_of_solution = end_of_solution;
				got.last            = last;
				sb.check_word(got);
			end
		end
	end

	// Sends one size word; called on a falling edge and returns on one.
	task automatic send_size(input logic [SIZE_W-1:0] size);
		int g;
		g = source_fast ? 0 : gap_length();
		repeat (g) @(negedge clk);
		in_valid   = 1'b1;
		board_size = size;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_size(size);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits until every expected word has come, and then waits on so that
	// the unit is back in its idle state.
	task automatic drain();
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CNT_W-1:0] value);
		drain();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		sb.limit_reg = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Random sizes: mostly small boards, occasionally a large one or a size
	// above the maximum that saturates.
	function automatic logic [SIZE_W-1:0] random_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return SIZE_W'($urandom_range(0, 9));
		if (r < 93)
			return SIZE_W'($urandom_range(10, 13));
		return SIZE_W'($urandom_range(14, 31));
	endfunction

	initial begin : stimulus
		logic [SIZE_W-1:0] directed_sizes[$];
		int i, p;
		sb          = new();
		sink_fast   = 1'b0;
		source_fast = 1'b0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		board_size  = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset limit of three: empty board, the sizes
		// with no solution, small boards, the largest board and sizes above
		// it that must saturate.
		directed_sizes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 16, 31, 17};
		foreach (directed_sizes[i])
			send_size(directed_sizes[i]);

		// A limit of zero behaves as one; then limits of one and two.
		write_limit(2'd0);
		send_size(5'd8);
		send_size(5'd3);
		send_size(5'd16);
		write_limit(2'd1);
		send_size(5'd1);
		send_size(5'd6);
		write_limit(2'd2);
		send_size(5'd4);
		send_size(5'd10);

		// Random phases under every limit; phase 2 runs sink and source without idling, phase 5 only the source.
		for (p = 0; p < 8; p++) begin
			write_limit(CNT_W'(p % 4));
			sink_fast   = (p == 2);
			source_fast = (p == 2) || (p == 5);
			for (i = 0; i < 15; i++) begin
				// Hold off once until the unit has delivered everything.
				if (p == 4 && i == 9)
					drain();
				send_size(random_size());
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
